// File: rtl/pplc_pkg.sv
// Shared types and constants for the PIN/PUK lock controller.
`default_nettype none

package pplc_pkg;

   localparam logic [7:0] CLASS_CARD      = 8'hA0;
   localparam logic [7:0] INS_VERIFY      = 8'h20;
   localparam logic [7:0] INS_CHANGE      = 8'h24;
   localparam logic [7:0] INS_UNBLOCK     = 8'h2C;
   localparam logic [7:0] INS_PERSONALIZE = 8'h40;
   localparam logic [7:0] DETAIL_BLOCKED  = 8'd255;
   localparam logic [7:0] DETAIL_PUK_BAD  = 8'd1;
   localparam logic [7:0] TRIES_BLOCKED   = 8'd255;
   localparam logic [7:0] TRIES_LIMIT     = 8'd4;
   localparam logic [1:0] MAX_TRIES_RESET = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      STATUS_DONE      = 3'd0,
      STATUS_LENGTH    = 3'd1,
      STATUS_STATE     = 3'd2,
      STATUS_INS       = 3'd3,
      STATUS_CLASS     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CARD_BLANK    = 2'd0,
      CARD_LOCKED   = 2'd1,
      CARD_BLOCKED  = 2'd2,
      CARD_UNLOCKED = 2'd3
   } card_state_type;

   typedef enum logic [2:0] {
      KIND_POWER,
      KIND_ERROR,
      KIND_PERSONALIZE,
      KIND_VERIFY,
      KIND_CHANGE,
      KIND_UNBLOCK
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [7:0]  detail;
      logic [63:0] code1;
      logic [63:0] code2;
   } entry_type;

   typedef struct packed {
      logic                full;
      logic                empty;
      logic [QCOUNT_W-1:0] count;
   } q_status_type;

endpackage

`default_nettype wire

// File: rtl/pplc_front.sv
// Command classifier: checks class, instruction and length, masks the codes.
`default_nettype none

module pplc_front #(
   parameter int CODE_BYTES = 8
) (
   input  wire logic        req_power_on,
   input  wire logic [7:0]  req_class_byte,
   input  wire logic [7:0]  req_command,
   input  wire logic [7:0]  req_length_byte,
   input  wire logic [63:0] req_first_code,
   input  wire logic [63:0] req_second_code,
   output pplc_pkg::entry_type entry
);
   import pplc_pkg::*;

   localparam int          CODE_BITS = CODE_BYTES * 8;
   localparam logic [63:0] CODE_MASK = {64{1'b1}} << (64 - CODE_BITS);
   localparam logic [7:0]  ONE_LEN   = 8'(CODE_BYTES);
   localparam logic [7:0]  TWO_LEN   = 8'(2 * CODE_BYTES);

   always_comb begin
      entry.kind   = KIND_ERROR;
      entry.status = STATUS_DONE;
      entry.detail = 8'd0;
      entry.code1  = req_first_code & CODE_MASK;
      entry.code2  = req_second_code & CODE_MASK;
      if (req_power_on) begin
         entry.kind = KIND_POWER;
      end else if (req_class_byte != CLASS_CARD) begin
         entry.status = STATUS_CLASS;
      end else begin
         case (req_command)
            INS_PERSONALIZE, INS_VERIFY: begin
               if (req_length_byte != ONE_LEN) begin
                  entry.status = STATUS_LENGTH;
                  entry.detail = ONE_LEN;
               end else if (req_command == INS_PERSONALIZE) begin
                  entry.kind = KIND_PERSONALIZE;
               end else begin
                  entry.kind = KIND_VERIFY;
               end
            end
            INS_CHANGE, INS_UNBLOCK: begin
               if (req_length_byte != TWO_LEN) begin
                  entry.status = STATUS_LENGTH;
                  entry.detail = TWO_LEN;
               end else if (req_command == INS_CHANGE) begin
                  entry.kind = KIND_CHANGE;
               end else begin
                  entry.kind = KIND_UNBLOCK;
               end
            end
            default: begin
               entry.status = STATUS_INS;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/pplc_queue.sv
// Short queue of classified commands between the front and back parts.
`default_nettype none

module pplc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire pplc_pkg::entry_type push_entry,
   input  wire logic                pop,
   output pplc_pkg::entry_type      head_entry,
   output pplc_pkg::q_status_type   q_status
);
   import pplc_pkg::*;

   localparam logic [QPTR_W-1:0]   PTR_LAST  = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCOUNT_W-1:0] COUNT_MAX = QCOUNT_W'(QUEUE_DEPTH);

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry     = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == COUNT_MAX);
   assign q_status.empty = (count_ff == '0);
   assign q_status.count = count_ff;

endmodule

`default_nettype wire

// File: rtl/pplc_back.sv
// Command executor: card state, stored codes, try counter and result register.
`default_nettype none

module pplc_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [1:0]             csr_write_data,
   input  wire pplc_pkg::entry_type    head_entry,
   input  wire pplc_pkg::q_status_type q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic [7:0]                  rsp_detail,
   output logic [1:0]                  rsp_card_state
);
   import pplc_pkg::*;

   card_state_type lock_state_ff, lock_state_in;
   logic [63:0]    pin_ff, pin_in;
   logic [63:0]    puk_ff, puk_in;
   logic [7:0]     tries_ff, tries_in;
   logic [1:0]     max_tries_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   status_type     status_ff, status_in;
   logic [7:0]     detail_ff, detail_in;
   logic [7:0]     restore;
   logic           pin_match;
   logic           puk_match;

   // take the next beat when the result slot is free or drains now
   assign pop       = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign restore   = (max_tries_ff == 2'd0) ? 8'd1 : {6'd0, max_tries_ff};
   assign pin_match = (head_entry.code1 == pin_ff);
   assign puk_match = (head_entry.code1 == puk_ff);

   always_comb begin
      lock_state_in = lock_state_ff;
      pin_in        = pin_ff;
      puk_in        = puk_ff;
      tries_in      = tries_ff;
      status_in     = STATUS_DONE;
      detail_in     = 8'd0;
      case (head_entry.kind)
         KIND_POWER: begin
            if (tries_ff == 8'd0) begin
               lock_state_in = CARD_BLANK;
            end else if (tries_ff < TRIES_LIMIT) begin
               lock_state_in = CARD_LOCKED;
            end else begin
               lock_state_in = CARD_BLOCKED;
            end
         end
         KIND_PERSONALIZE: begin
            if (lock_state_ff != CARD_BLANK) begin
               status_in = STATUS_STATE;
            end else begin
               puk_in        = head_entry.code1;
               tries_in      = restore;
               lock_state_in = CARD_LOCKED;
            end
         end
         KIND_VERIFY: begin
            if (lock_state_ff != CARD_LOCKED) begin
               status_in = STATUS_STATE;
            end else if (pin_match) begin
               lock_state_in = CARD_UNLOCKED;
               tries_in      = restore;
            end else if (tries_ff <= 8'd1) begin
               // last try used: block the card
               lock_state_in = CARD_BLOCKED;
               tries_in      = TRIES_BLOCKED;
               detail_in     = DETAIL_BLOCKED;
            end else begin
               tries_in  = tries_ff - 8'd1;
               detail_in = tries_ff - 8'd1;
            end
         end
         KIND_CHANGE: begin
            if (lock_state_ff != CARD_UNLOCKED) begin
               status_in = STATUS_STATE;
            end else if (pin_match) begin
               pin_in = head_entry.code2;
            end else begin
               detail_in = DETAIL_BLOCKED;
            end
         end
         KIND_UNBLOCK: begin
            if (lock_state_ff != CARD_BLOCKED) begin
               status_in = STATUS_STATE;
            end else if (puk_match) begin
               lock_state_in = CARD_LOCKED;
               pin_in        = head_entry.code2;
               tries_in      = restore;
            end else begin
               detail_in = DETAIL_PUK_BAD;
            end
         end
         default: begin
            status_in = head_entry.status;
            detail_in = head_entry.detail;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_state_ff <= CARD_BLANK;
         pin_ff        <= '0;
         puk_ff        <= '0;
         tries_ff      <= '0;
         max_tries_ff  <= MAX_TRIES_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_tries_ff <= csr_write_data;
         end
         if (pop) begin
            lock_state_ff <= lock_state_in;
            pin_ff        <= pin_in;
            puk_ff        <= puk_in;
            tries_ff      <= tries_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, held while the beat stalls
   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         detail_ff <= detail_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_detail     = detail_ff;
   assign rsp_card_state = lock_state_ff;

endmodule

`default_nettype wire

// File: rtl/pin_puk_lock_controller_core.sv
// PIN/PUK lock controller top level: classifier, command queue and executor.
// A command is first written into a queue slot, then executed into the result register.
// Throughput: one command per cycle while the result register is free or being taken.
// The two-entry queue absorbs a stalled result; req_ready drops only when it is full.
// Reset: synchronous; card blank, codes and try counter zero, max_tries back to 3.
`default_nettype none

module pin_puk_lock_controller_core #(
   parameter int CODE_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_power_on,
   input  wire logic [7:0]  req_class_byte,
   input  wire logic [7:0]  req_command,
   input  wire logic [7:0]  req_length_byte,
   input  wire logic [63:0] req_first_code,
   input  wire logic [63:0] req_second_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_detail,
   output logic [1:0]       rsp_card_state
);
   import pplc_pkg::*;

   localparam logic [7:0]          ONE_LEN   = 8'(CODE_BYTES);
   localparam logic [7:0]          TWO_LEN   = 8'(2 * CODE_BYTES);
   localparam logic [QCOUNT_W-1:0] COUNT_MAX = QCOUNT_W'(QUEUE_DEPTH);

   entry_type    front_entry;
   entry_type    head_entry;
   q_status_type q_status;
   logic         push;
   logic         pop;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   pplc_front #(
      .CODE_BYTES (CODE_BYTES)
   ) u_front (
      .req_power_on    (req_power_on),
      .req_class_byte  (req_class_byte),
      .req_command     (req_command),
      .req_length_byte (req_length_byte),
      .req_first_code  (req_first_code),
      .req_second_code (req_second_code),
      .entry           (front_entry)
   );

   pplc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   pplc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_entry       (head_entry),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_detail       (rsp_detail),
      .rsp_card_state   (rsp_card_state)
   );

   a_ready_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (q_status.count == COUNT_MAX))
      else $error("input stalled with room in the queue");

   a_pop_has_room: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before it was taken");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_length_detail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_LENGTH) |->
         (rsp_detail == ONE_LEN || rsp_detail == TWO_LEN))
      else $error("length error without expected length");

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the PIN/PUK lock controller core.
`timescale 1ns / 100ps

module tb;
   import pplc_pkg::*;

   localparam int          CODE_BYTES   = 8;
   localparam int          CLOCK_PERIOD = 10;
   localparam int          RESET_CYCLES = 12;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          CYCLE_LIMIT  = 600000;
   localparam int          REPORT_LIMIT = 10;
   localparam logic [7:0]  ONE_LEN      = 8'(CODE_BYTES);
   localparam logic [7:0]  TWO_LEN      = 8'(2 * CODE_BYTES);
   localparam logic [63:0] CODE_MASK    =
      (CODE_BYTES >= 8) ? {64{1'b1}} : ~({64{1'b1}} >> (CODE_BYTES * 8));
   localparam logic [63:0] ALL_ONES     = {64{1'b1}};

   typedef struct packed {
      logic        power_on;
      logic [7:0]  class_byte;
      logic [7:0]  command;
      logic [7:0]  length_byte;
      logic [63:0] first_code;
      logic [63:0] second_code;
   } card_command_type;

   typedef struct packed {
      status_type     status;
      logic [7:0]     detail;
      card_state_type card_state;
   } card_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_power_on = 1'b0;
   logic [7:0]  req_class_byte = '0;
   logic [7:0]  req_command = '0;
   logic [7:0]  req_length_byte = '0;
   logic [63:0] req_first_code = '0;
   logic [63:0] req_second_code = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_detail;
   logic [1:0]  rsp_card_state;

   // Shadow of the card as the block should hold it
   card_state_type shadow_state     = CARD_BLANK;
   logic [63:0]    shadow_pin       = '0;
   logic [63:0]    shadow_puk       = '0;
   logic [7:0]     shadow_tries     = '0;
   logic [1:0]     shadow_max_tries = MAX_TRIES_RESET;

   card_answer_type pending_answers[$];
   int              fail_count      = 0;
   int              cycle_count     = 0;
   int              rsp_hold_cycles = 0;
   bit              req_gaps_on     = 1'b1;
   bit              rsp_stalls_on   = 1'b1;

   pin_puk_lock_controller_core #(.CODE_BYTES(CODE_BYTES)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_power_on     (req_power_on),
      .req_class_byte   (req_class_byte),
      .req_command      (req_command),
      .req_length_byte  (req_length_byte),
      .req_first_code   (req_first_code),
      .req_second_code  (req_second_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_detail       (rsp_detail),
      .rsp_card_state   (rsp_card_state)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Apply one command to the shadow card and return the answer it must give
   function automatic card_answer_type card_answer(input card_command_type cmd);
      card_answer_type ans;
      card_state_type  need;
      logic [63:0]     code1;
      logic [63:0]     code2;
      logic [7:0]      restore;
      ans.status = STATUS_DONE;
      ans.detail = '0;
      code1 = cmd.first_code & CODE_MASK;
      code2 = cmd.second_code & CODE_MASK;
      restore = (shadow_max_tries == 2'd0) ? 8'd1 : {6'd0, shadow_max_tries};
      if (cmd.power_on) begin
         if (shadow_tries == 8'd0) shadow_state = CARD_BLANK;
         else if (shadow_tries < TRIES_LIMIT) shadow_state = CARD_LOCKED;
         else shadow_state = CARD_BLOCKED;
      end else if (cmd.class_byte != CLASS_CARD) begin
         ans.status = STATUS_CLASS;
      end else if (cmd.command == INS_PERSONALIZE || cmd.command == INS_VERIFY) begin
         need = (cmd.command == INS_PERSONALIZE) ? CARD_BLANK : CARD_LOCKED;
         if (cmd.length_byte != ONE_LEN) begin
            ans.status = STATUS_LENGTH;
            ans.detail = ONE_LEN;
         end else if (shadow_state != need) begin
            ans.status = STATUS_STATE;
         end else if (cmd.command == INS_PERSONALIZE) begin
            shadow_puk   = code1;
            shadow_tries = restore;
            shadow_state = CARD_LOCKED;
         end else if (code1 == (shadow_pin & CODE_MASK)) begin
            shadow_state = CARD_UNLOCKED;
            shadow_tries = restore;
         end else if (shadow_tries <= 8'd1) begin
            // last try used: block
            shadow_state = CARD_BLOCKED;
            shadow_tries = TRIES_BLOCKED;
            ans.detail   = DETAIL_BLOCKED;
         end else begin
            shadow_tries = shadow_tries - 8'd1;
            ans.detail   = shadow_tries;
         end
      end else if (cmd.command == INS_CHANGE || cmd.command == INS_UNBLOCK) begin
         need = (cmd.command == INS_CHANGE) ? CARD_UNLOCKED : CARD_BLOCKED;
         if (cmd.length_byte != TWO_LEN) begin
            ans.status = STATUS_LENGTH;
            ans.detail = TWO_LEN;
         end else if (shadow_state != need) begin
            ans.status = STATUS_STATE;
         end else if (cmd.command == INS_CHANGE) begin
            if (code1 == (shadow_pin & CODE_MASK)) shadow_pin = code2;
            else ans.detail = DETAIL_BLOCKED;
         end else if (code1 == (shadow_puk & CODE_MASK)) begin
            shadow_state = CARD_LOCKED;
            shadow_pin   = code2;
            shadow_tries = restore;
         end else begin
            ans.detail = DETAIL_PUK_BAD;
         end
      end else begin
         ans.status = STATUS_INS;
      end
      ans.card_state = shadow_state;
      return ans;
   endfunction

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] known_ins(input int unsigned pick);
      case (pick)
         0:       return INS_VERIFY;
         1:       return INS_CHANGE;
         2:       return INS_UNBLOCK;
         default: return INS_PERSONALIZE;
      endcase
   endfunction

   function automatic card_command_type make_command(input logic [7:0] ins,
                                                     input logic [7:0] len,
                                                     input logic [63:0] code1,
                                                     input logic [63:0] code2);
      card_command_type cmd;
      cmd.power_on    = 1'b0;
      cmd.class_byte  = CLASS_CARD;
      cmd.command     = ins;
      cmd.length_byte = len;
      cmd.first_code  = code1;
      cmd.second_code = code2;
      return cmd;
   endfunction

   function automatic card_command_type power_cycle();
      card_command_type cmd;
      cmd.power_on    = 1'b1;
      cmd.class_byte  = 8'($urandom);
      cmd.command     = 8'($urandom);
      cmd.length_byte = 8'($urandom);
      cmd.first_code  = {$urandom, $urandom};
      cmd.second_code = {$urandom, $urandom};
      return cmd;
   endfunction

   // Mostly commands that fit the card's state, with the right code most of the time
   function automatic card_command_type random_command();
      card_command_type cmd;
      logic [63:0]      known;
      int unsigned      roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return power_cycle();
      cmd = make_command(INS_VERIFY, ONE_LEN, {$urandom, $urandom}, {$urandom, $urandom});
      if (roll < 75) begin
         case (shadow_state)
            CARD_BLANK:    cmd.command = INS_PERSONALIZE;
            CARD_LOCKED:   cmd.command = INS_VERIFY;
            CARD_UNLOCKED: cmd.command = INS_CHANGE;
            default:       cmd.command = INS_UNBLOCK;
         endcase
         if ($urandom_range(0, 9) == 0) cmd.command = known_ins($urandom_range(0, 3));
         cmd.length_byte = (cmd.command == INS_VERIFY || cmd.command == INS_PERSONALIZE) ?
                           ONE_LEN : TWO_LEN;
         known = (cmd.command == INS_UNBLOCK) ? shadow_puk : shadow_pin;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: cmd.first_code = known;
            6:                cmd.first_code = known ^ (64'd1 << $urandom_range(0, 63));
            default:          ;
         endcase
      end else begin
         if ($urandom_range(0, 3) == 0) cmd.class_byte = 8'($urandom);
         cmd.command = ($urandom_range(0, 4) == 4) ? 8'($urandom) :
                       known_ins($urandom_range(0, 3));
         case ($urandom_range(0, 2))
            0:       cmd.length_byte = ONE_LEN;
            1:       cmd.length_byte = TWO_LEN;
            default: cmd.length_byte = 8'($urandom);
         endcase
      end
      return cmd;
   endfunction

   task automatic send_command(input card_command_type cmd);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_power_on    <= cmd.power_on;
      req_class_byte  <= cmd.class_byte;
      req_command     <= cmd.command;
      req_length_byte <= cmd.length_byte;
      req_first_code  <= cmd.first_code;
      req_second_code <= cmd.second_code;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pending_answers.push_back(card_answer(cmd));
   endtask

   // Drop valid and hold until every predicted answer has come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_max_tries(input logic [1:0] setting);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_max_tries = setting;
   endtask

   task automatic test_directed_commands();
      card_command_type wake;
      wake = '{power_on: 1'b1, class_byte: 8'hFF, command: 8'hFF, length_byte: 8'hFF,
               first_code: ALL_ONES, second_code: ALL_ONES};
      send_command(wake);
      send_command(make_command(INS_VERIFY, ONE_LEN, '0, '0));
      send_command('{1'b0, 8'h00, INS_VERIFY, ONE_LEN, 64'd0, 64'd0});
      send_command('{1'b0, 8'hFF, INS_VERIFY, ONE_LEN, 64'd0, 64'd0});
      send_command(make_command(8'h00, ONE_LEN, '0, '0));
      send_command(make_command(8'hFF, ONE_LEN, '0, '0));
      send_command(make_command(INS_VERIFY, 8'h00, '0, '0));
      send_command(make_command(INS_CHANGE, 8'hFF, '0, '0));
      send_command(make_command(INS_UNBLOCK, ONE_LEN, '0, '0));
      send_command(make_command(INS_PERSONALIZE, TWO_LEN, '0, '0));
      // blank card refuses everything but personalize
      send_command(make_command(INS_VERIFY, ONE_LEN, '0, '0));
      send_command(make_command(INS_CHANGE, TWO_LEN, '0, '0));
      send_command(make_command(INS_UNBLOCK, TWO_LEN, '0, '0));
      send_command(make_command(INS_PERSONALIZE, ONE_LEN, ALL_ONES, ALL_ONES));
      send_command(make_command(INS_PERSONALIZE, ONE_LEN, '0, '0));
      // use up every try
      repeat (3) send_command(make_command(INS_VERIFY, ONE_LEN, ALL_ONES, '0));
      send_command(power_cycle());
      send_command(make_command(INS_UNBLOCK, TWO_LEN, '0, ALL_ONES));
      send_command(make_command(INS_UNBLOCK, TWO_LEN, ALL_ONES, 64'h0123_4567_89AB_CDEF));
      send_command(make_command(INS_VERIFY, ONE_LEN, 64'h0123_4567_89AB_CDEF, '0));
      send_command(make_command(INS_CHANGE, TWO_LEN, '0, ALL_ONES));
      send_command(make_command(INS_CHANGE, TWO_LEN, 64'h0123_4567_89AB_CDEF, ALL_ONES));
      send_command(power_cycle());
      send_command(make_command(INS_VERIFY, ONE_LEN, ALL_ONES, '0));
   endtask

   // Walk restore and block at try limits 1, 0 and 2, zero among them
   task automatic test_try_limits();
      logic [1:0] setting;
      for (int k = 0; k < 3; k++) begin
         setting = (k == 0) ? 2'd1 : (k == 1) ? 2'd0 : 2'd2;
         wait_for_drain();
         write_max_tries(setting);
         send_command(power_cycle());
         if (shadow_state == CARD_BLOCKED)
            send_command(make_command(INS_UNBLOCK, TWO_LEN, shadow_puk, {$urandom, $urandom}));
         send_command(make_command(INS_VERIFY, ONE_LEN, shadow_pin, '0));
         send_command(power_cycle());
         while (shadow_state != CARD_BLOCKED)
            send_command(make_command(INS_VERIFY, ONE_LEN, ~shadow_pin, '0));
         send_command(make_command(INS_UNBLOCK, TWO_LEN, shadow_puk, {$urandom, $urandom}));
      end
   endtask

   task automatic test_result_backpressure();
      wait_for_drain();
      req_gaps_on     = 1'b0;
      rsp_hold_cycles = 300;
      repeat (40) send_command(random_command());
      wait_for_drain();
      req_gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic(input logic [1:0] setting, input int count);
      wait_for_drain();
      write_max_tries(setting);
      for (int i = 0; i < count; i++) begin
         // switch idling on and off in stretches
         if (i % 60 == 0) begin
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
         end
         send_command(random_command());
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles = rsp_hold_cycles - 1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_stalls_on) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      card_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("unexpected answer beat: status %0d detail %0d state %0d",
                        rsp_status, rsp_detail, rsp_card_state);
            fail_count = fail_count + 1;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status || rsp_detail !== want.detail ||
                rsp_card_state !== want.card_state) begin
               if (fail_count < REPORT_LIMIT)
                  $display("answer mismatch: status %0d/%0d detail %0d/%0d state %0d/%0d",
                           want.status, rsp_status, want.detail, rsp_detail,
                           want.card_state, rsp_card_state);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_commands();
      test_try_limits();
      test_result_backpressure();
      test_random_traffic(2'd3, 450);
      test_random_traffic(2'd1, 450);
      test_random_traffic(2'd0, 450);
      test_random_traffic(2'd2, 450);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
